>>> hdl/cbm_pkg.sv
package cbm_pkg;

    // Defaults for the top-level parameters.
    localparam int TABLE_ENTRIES_DEF    = 4096;
    localparam int BLOCK_BITS_DEF       = 16;
    localparam int MAX_READ_SECTORS_DEF = 2048;

    // A sector is 512 bytes.
    localparam int SECTOR_SHIFT = 9;

    // Fixed field widths.
    localparam int SECTOR_W = 48;
    localparam int COUNT_W  = 12;
    localparam int INDEX_W  = 12;
    localparam int BASE_W   = 31;
    localparam int BUF_W    = 11;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_READ = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_SEGMENT = 2'd0,
        STAT_PASS    = 2'd1,
        STAT_EOM     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_CHK2,
        S_SEG_RD,
        S_SEG_FIRST,
        S_EXT,
        S_EMIT
    } t_state;

    // One block map entry.
    typedef struct packed {
        logic              allocated;
        logic [BASE_W-1:0] base;
    } t_entry;

    // One result transaction.
    typedef struct packed {
        t_status             status;
        logic                from_diff;
        logic [SECTOR_W-1:0] device_sector;
        logic [COUNT_W-1:0]  segment_sectors;
        logic [BUF_W-1:0]    buffer_sector;
        logic                last;
    } t_result;

endpackage

>>> hdl/cbm_map_ram.sv
module cbm_map_ram
    import cbm_pkg::*;
#(
    parameter int DEPTH  = TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(TABLE_ENTRIES_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/cbm_out_reg.sv
module cbm_out_reg
    import cbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_out_stall
);

    logic    r_valid;
    t_result r_result;

    // The register can take a new result when empty or when its content leaves now.
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> hdl/cbm_splitter_ctrl.sv
module cbm_splitter_ctrl
    import cbm_pkg::*;
#(
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF,
    parameter int BLOCK_BITS       = BLOCK_BITS_DEF,
    parameter int MAX_READ_SECTORS = MAX_READ_SECTORS_DEF,
    parameter int IDXW             = $clog2(TABLE_ENTRIES_DEF)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic                i_entry_allocated,
    input  logic [BASE_W-1:0]   i_entry_base,
    input  logic [SECTOR_W-1:0] i_start_sector,
    input  logic [COUNT_W-1:0]  i_sector_count,
    input  logic [SECTOR_W-1:0] i_disk_sectors,
    output logic                o_rd_en,
    output logic [IDXW-1:0]     o_rd_addr,
    input  t_entry              i_rd_data,
    output logic                o_wr_en,
    output logic [IDXW-1:0]     o_wr_addr,
    output t_entry              o_wr_data,
    output logic                o_push,
    output t_result             o_result,
    input  logic                i_push_ready
);

    localparam int SB     = BLOCK_BITS - SECTOR_SHIFT;
    localparam int RUN_W  = ((SB > COUNT_W) ? SB : COUNT_W) + 1;
    localparam int END_W  = SECTOR_W + 1;
    localparam logic [RUN_W-1:0] SPB = RUN_W'(1) << SB;
    localparam logic [END_W-1:0] END_LIMIT = END_W'(TABLE_ENTRIES) << SB;
    localparam logic [IDXW-1:0]  LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

    t_state              r_state, n_state;
    logic [IDXW-1:0]     r_clr_addr;
    logic [SECTOR_W-1:0] r_start;
    logic [COUNT_W-1:0]  r_count;
    t_status             r_kind;
    logic [END_W-1:0]    r_end;
    logic [SECTOR_W-1:0] r_pos;
    logic [COUNT_W-1:0]  r_rem;
    logic [COUNT_W-1:0]  r_sectors_done;
    logic [IDXW-1:0]     r_walk_block;
    t_entry              r_first;
    t_entry              r_cur;
    logic [RUN_W-1:0]    r_run;

    logic [SB-1:0]       w_off;
    logic [RUN_W-1:0]    w_rem_ext;
    logic [RUN_W-1:0]    w_run_init;
    logic [RUN_W-1:0]    w_run_ext;
    logic                w_join;
    logic                w_eom;
    logic                w_last;
    logic [COUNT_W-1:0]  w_seg_len;
    logic [SECTOR_W-1:0] w_diff_dev;
    logic                w_accept;

    // A block joins the run when both are unallocated, or when both are
    // allocated and the next base follows the current one without wrapping.
    function automatic logic joins(t_entry cur, t_entry nxt);
        logic res;
        if (cur.allocated) begin
            res = nxt.allocated && ({1'b0, nxt.base} == ({1'b0, cur.base} + 32'd1));
        end else begin
            res = !nxt.allocated;
        end
        return res;
    endfunction

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_off      = r_pos[SB-1:0];
    assign w_rem_ext  = RUN_W'(r_rem);
    assign w_run_init = SPB - RUN_W'(w_off);
    assign w_run_ext  = r_run + SPB;
    assign w_join     = joins(r_cur, i_rd_data);
    assign w_eom      = (32'(r_count) > 32'(MAX_READ_SECTORS))
                     || (r_start >= i_disk_sectors)
                     || (r_end > END_W'(i_disk_sectors))
                     || (r_end > END_LIMIT);
    assign w_last     = (r_run >= w_rem_ext);
    assign w_seg_len  = w_last ? r_rem : r_run[COUNT_W-1:0];
    assign w_diff_dev = SECTOR_W'({r_first.base, w_off});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && (i_req_type == REQ_READ)) begin
                    n_state = (i_sector_count == '0) ? S_EMIT : S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_CHK2;
            end
            S_CHK2: begin
                n_state = w_eom ? S_EMIT : S_SEG_RD;
            end
            S_SEG_RD: begin
                n_state = S_SEG_FIRST;
            end
            S_SEG_FIRST: begin
                n_state = (w_run_init < w_rem_ext) ? S_EXT : S_EMIT;
            end
            S_EXT: begin
                n_state = (w_join && (w_run_ext < w_rem_ext)) ? S_EXT : S_EMIT;
            end
            S_EMIT: begin
                if (i_push_ready) begin
                    n_state = ((r_kind != STAT_SEGMENT) || w_last) ? S_IDLE : S_SEG_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        o_rd_en    = 1'b0;
        o_rd_addr  = r_walk_block;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_clr_addr;
        o_wr_data  = '0;
        o_push     = 1'b0;
        o_result   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_wr_en = 1'b1;
            end
            S_IDLE: begin
                o_wr_en   = w_accept && (i_req_type == REQ_LOAD)
                         && (32'(i_entry_index) < 32'(TABLE_ENTRIES));
                o_wr_addr = IDXW'(i_entry_index);
                o_wr_data = '{allocated: i_entry_allocated, base: i_entry_base};
            end
            S_SEG_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_pos[SB +: IDXW];
            end
            S_SEG_FIRST: begin
                o_rd_en   = (w_run_init < w_rem_ext);
                o_rd_addr = r_walk_block + IDXW'(1);
            end
            S_EXT: begin
                o_rd_en   = w_join && (w_run_ext < w_rem_ext);
                o_rd_addr = r_walk_block + IDXW'(2);
            end
            S_EMIT: begin
                o_push = 1'b1;
                unique case (r_kind)
                    STAT_PASS: begin
                        o_result.status        = STAT_PASS;
                        o_result.device_sector = r_start;
                        o_result.last          = 1'b1;
                    end
                    STAT_EOM: begin
                        o_result.status = STAT_EOM;
                        o_result.last   = 1'b1;
                    end
                    default: begin
                        o_result.status          = STAT_SEGMENT;
                        o_result.from_diff       = r_first.allocated;
                        o_result.device_sector   = r_first.allocated ? w_diff_dev : r_pos;
                        o_result.segment_sectors = w_seg_len;
                        o_result.buffer_sector   = r_sectors_done[BUF_W-1:0];
                        o_result.last            = w_last;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDXW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req_type == REQ_READ)) begin
                    r_start <= i_start_sector;
                    r_count <= i_sector_count;
                    r_kind  <= (i_sector_count == '0) ? STAT_PASS : STAT_SEGMENT;
                end
            end
            S_CHK: begin
                r_end <= END_W'(r_start) + END_W'(r_count);
            end
            S_CHK2: begin
                r_kind         <= w_eom ? STAT_EOM : STAT_SEGMENT;
                r_pos          <= r_start;
                r_rem          <= r_count;
                r_sectors_done <= '0;
            end
            S_SEG_RD: begin
                r_walk_block <= r_pos[SB +: IDXW];
            end
            S_SEG_FIRST: begin
                r_first <= i_rd_data;
                r_cur   <= i_rd_data;
                r_run   <= w_run_init;
            end
            S_EXT: begin
                if (w_join) begin
                    r_run        <= w_run_ext;
                    r_walk_block <= r_walk_block + IDXW'(1);
                    r_cur        <= i_rd_data;
                end
            end
            S_EMIT: begin
                if (i_push_ready && (r_kind == STAT_SEGMENT)) begin
                    r_pos          <= r_pos + SECTOR_W'(w_seg_len);
                    r_rem          <= r_rem - w_seg_len;
                    r_sectors_done <= r_sectors_done + w_seg_len;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_walk_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEG_RD) || (r_state == S_SEG_FIRST) || (r_state == S_EXT))
        |-> (r_rem != '0))
        else $error("walk running with no sectors left");

    a_walk_accounts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEG_RD) || (r_state == S_SEG_FIRST) || (r_state == S_EXT))
        |-> (({1'b0, r_sectors_done} + {1'b0, r_rem}) == {1'b0, r_count}))
        else $error("covered and remaining sectors do not add up to the request");

    a_ext_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXT) |-> (r_run < w_rem_ext))
        else $error("extending a run that already covers the request");

    a_rd_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (32'(o_rd_addr) < 32'(TABLE_ENTRIES)))
        else $error("map read beyond the table");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG_FIRST) |-> $past(o_rd_en))
        else $error("entry used without a read issued");
`endif

endmodule

>>> hdl/cow_block_map_read_splitter.sv
// Copy-on-write block map read splitter. The block holds a map of TABLE_ENTRIES
// entries, one per block of 2**BLOCK_BITS bytes, each saying whether the block
// was copied to the diff store and where. A load transaction (req_type 0)
// writes one entry and produces no result; an index past the
// table is ignored. A read transaction (req_type 1) gives a start sector and a
// count and is answered by one or more result transactions, the final one with
// last set: a pass-through result for a zero-length read, an end-of-media
// result when the range crosses disk_sectors, the end of the table or
// MAX_READ_SECTORS, and otherwise one segment per run of unallocated blocks
// or per run of allocated blocks whose diff-store bases rise by one.
// After reset the map is cleared one entry per cycle, so no transaction is
// taken until every one of the TABLE_ENTRIES entries has been written;
// configuration writes are taken at any time. A zero-length read goes straight
// to its result; an end-of-media read first passes the range checks S_CHK and
// S_CHK2. A read that is split passes the range checks and then, per segment,
// reads the first block, takes its entry, looks at each further block in turn
// (every block merged into the segment and, when the segment ends before the
// read does, the block that ends it) and emits the segment. The walk is bound
// by the single read port of the map memory and its registered read: the walk
// reads one entry per cycle and decides on it before reading the next.
// A read also waits while the result register is full and held by i_out_stall.
// The next transaction is taken once the last result of a read has entered
// the output register, even while that result still waits to be taken.
// disk_sectors is written through i_cfg_wr_en and i_cfg_wr_data and must only
// change while the block is idle.
module cow_block_map_read_splitter
    import cbm_pkg::*;
#(
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF,
    parameter int BLOCK_BITS       = BLOCK_BITS_DEF,
    parameter int MAX_READ_SECTORS = MAX_READ_SECTORS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration: the disk size in sectors.
    input  logic                i_cfg_wr_en,
    input  logic [SECTOR_W-1:0] i_cfg_wr_data,

    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic                i_entry_allocated,
    input  logic [BASE_W-1:0]   i_entry_base,
    input  logic [SECTOR_W-1:0] i_start_sector,
    input  logic [COUNT_W-1:0]  i_sector_count,

    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic                o_from_diff,
    output logic [SECTOR_W-1:0] o_device_sector,
    output logic [COUNT_W-1:0]  o_segment_sectors,
    output logic [BUF_W-1:0]    o_buffer_sector,
    output logic                o_last
);

    localparam int IDXW = $clog2(TABLE_ENTRIES);

    logic [SECTOR_W-1:0] r_disk_sectors;

    logic            w_rd_en;
    logic [IDXW-1:0] w_rd_addr;
    t_entry          w_rd_data;
    logic            w_wr_en;
    logic [IDXW-1:0] w_wr_addr;
    t_entry          w_wr_data;
    logic            w_push;
    logic            w_push_ready;
    t_result         w_push_result;
    t_result         w_out_result;

    // The disk size register. Reset makes every read of nonzero length an
    // end-of-media read until the size is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_sectors <= '0;
        end else if (i_cfg_wr_en) begin
            r_disk_sectors <= i_cfg_wr_data;
        end
    end

    // The map itself: one write port shared by the clearing pass and map
    // loads, one read port used by the walk.
    cbm_map_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDXW)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // The sequencer: clearing pass, range checks and the map walk that
    // builds each segment.
    cbm_splitter_ctrl #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .BLOCK_BITS       (BLOCK_BITS),
        .MAX_READ_SECTORS (MAX_READ_SECTORS),
        .IDXW             (IDXW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_entry_index     (i_entry_index),
        .i_entry_allocated (i_entry_allocated),
        .i_entry_base      (i_entry_base),
        .i_start_sector    (i_start_sector),
        .i_sector_count    (i_sector_count),
        .i_disk_sectors    (r_disk_sectors),
        .o_rd_en           (w_rd_en),
        .o_rd_addr         (w_rd_addr),
        .i_rd_data         (w_rd_data),
        .o_wr_en           (w_wr_en),
        .o_wr_addr         (w_wr_addr),
        .o_wr_data         (w_wr_data),
        .o_push            (w_push),
        .o_result          (w_push_result),
        .i_push_ready      (w_push_ready)
    );

    // The result register decouples the walk from the consumer.
    cbm_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_result    (w_push_result),
        .o_ready     (w_push_ready),
        .o_valid     (o_out_valid),
        .o_result    (w_out_result),
        .i_out_stall (i_out_stall)
    );

    assign o_status          = w_out_result.status;
    assign o_from_diff       = w_out_result.from_diff;
    assign o_device_sector   = w_out_result.device_sector;
    assign o_segment_sectors = w_out_result.segment_sectors;
    assign o_buffer_sector   = w_out_result.buffer_sector;
    assign o_last            = w_out_result.last;

endmodule
